/* src/rde_pkg.sv */
// ----------------------------------------------------------------------------
// rde_pkg: shared definitions for the radix digit emitter
// Character codes, request codes, digit buffer sizes and controller states.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  localparam logic [6:0] DIGIT_COUNT_RESET = 7'd10;

  localparam int MAX_DIGITS  = 32;
  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
  localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_A,
    ST_CHK_B,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_POP,
    ST_LOOK,
    ST_EMIT
  } rde_state_t;

endpackage

/* src/rde_if.sv */
// ----------------------------------------------------------------------------
// rde_if: request and response channels of the radix digit emitter
// Each channel moves one word per valid and ready handshake.
// ----------------------------------------------------------------------------
interface rde_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [5:0]         symbol_index;
  logic [7:0]         symbol_char;
  logic signed [31:0] number;

  modport source (output valid, req_type, symbol_index, symbol_char, number, input ready);
  modport sink   (input valid, req_type, symbol_index, symbol_char, number, output ready);
endinterface

interface rde_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

/* src/rde_alpha_store.sv */
// ----------------------------------------------------------------------------
// rde_alpha_store: alphabet symbol memory
// One write port and one registered read port; entries never written read
// as zero through per-entry valid bits that reset clears.
// ----------------------------------------------------------------------------
module rde_alpha_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          rd_en,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]       mem_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= valid[raddr];
      end
    end
  end

  assign rdata = vld_q ? mem_q : 8'd0;

endmodule

/* src/rde_divider.sv */
// ----------------------------------------------------------------------------
// rde_divider: restoring divider, one quotient bit per cycle
// Divides a 32-bit unsigned value by a narrow divisor in 32 steps and pulses
// done when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module rde_divider #(
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [31:0]   quotient,
  output logic [DW-1:0] remainder
);

  logic          busy;
  logic [4:0]    cnt;
  logic [31:0]   quo;
  logic [DW-1:0] rem;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, quo[31]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[30:0], fits};
      rem <= fits ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* src/radix_digit_emitter_unit.sv */
// ----------------------------------------------------------------------------
// radix_digit_emitter_unit: signed integer to text in a programmable radix
// Writes alphabet symbols and converts 32-bit numbers into character words.
// ----------------------------------------------------------------------------
// A convert first checks the alphabet through the single read port of the
// symbol memory; each digit then comes from the one-bit-per-cycle divider,
// and each character leaves through the digit buffer and symbol memory. New
// requests are taken only in the idle state, which a convert reaches again
// once its final character is in the output register or its alphabet check
// has failed. The symbol memory needs no clearing pass after reset.
module radix_digit_emitter_unit #(
  parameter int MAX_BASE = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       digit_count_we,
  input  logic [6:0] digit_count_wdata,
  rde_in_if.sink     req,
  rde_out_if.source  rsp
);

  localparam int AW = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1;
  localparam int CW = $clog2(MAX_BASE + 1);
  localparam int IW = rde_pkg::DIGIT_IDX_W;
  localparam int NW = rde_pkg::DIGIT_CNT_W;

  rde_pkg::rde_state_t state, state_next;

  logic [6:0]    digit_count;
  logic [CW-1:0] radix;
  logic [CW-1:0] a_idx;
  logic [CW-1:0] b_idx;
  logic [CW-1:0] a_inc;
  logic [CW-1:0] b_inc;
  logic [7:0]    sym_a;
  logic          neg;
  logic [31:0]   mag;
  logic [31:0]   raw;
  logic [NW-1:0] nd;
  logic [NW-1:0] nd_inc;
  logic [IW-1:0] k_idx;
  logic [AW-1:0] stack [rde_pkg::MAX_DIGITS];
  logic [AW-1:0] stack_q;

  logic          out_valid;
  logic [7:0]    out_char;
  logic          out_last;
  logic          out_free;

  logic          accept;
  logic          range_ok;
  logic          alpha_we;
  logic          alpha_rd_en;
  logic [AW-1:0] alpha_raddr;
  logic [7:0]    alpha_rdata;
  logic          sym_bad;
  logic          sym_dup;
  logic          last_a;
  logic          last_b;

  logic          div_start;
  logic          div_done;
  logic [31:0]   div_quo;
  logic [CW-1:0] div_rem;
  logic          digits_done;

  logic          stack_we;
  logic          stack_rd;
  logic          out_load;
  logic [7:0]    out_load_char;
  logic          out_load_last;

  assign raw      = req.number;
  assign accept   = req.valid && req.ready;
  assign range_ok = (digit_count >= 7'd2) && (int'(digit_count) <= MAX_BASE);
  assign alpha_we = accept && (req.req_type == rde_pkg::REQ_WRITE)
                    && (int'(req.symbol_index) < MAX_BASE);

  assign a_inc   = CW'(a_idx + CW'(1));
  assign b_inc   = CW'(b_idx + CW'(1));
  assign last_a  = (a_inc == radix);
  assign last_b  = (b_inc == radix);
  assign sym_bad = (alpha_rdata == rde_pkg::CH_PLUS) || (alpha_rdata == rde_pkg::CH_MINUS);
  assign sym_dup = (alpha_rdata == sym_a);
  assign nd_inc  = NW'(nd + NW'(1));
  assign digits_done = (div_quo == 32'd0) || (int'(nd_inc) == rde_pkg::MAX_DIGITS);
  assign out_free    = !out_valid || rsp.ready;

  rde_alpha_store #(
    .DEPTH (MAX_BASE),
    .AW    (AW)
  ) u_alpha (
    .clk   (clk),
    .rst   (rst),
    .we    (alpha_we),
    .waddr (AW'(req.symbol_index)),
    .wdata (req.symbol_char),
    .rd_en (alpha_rd_en),
    .raddr (alpha_raddr),
    .rdata (alpha_rdata)
  );

  rde_divider #(
    .DW (CW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (radix),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    case (state)
      rde_pkg::ST_IDLE: begin
        if (accept && (req.req_type == rde_pkg::REQ_CONVERT) && range_ok) begin
          state_next = rde_pkg::ST_CHK_A;
        end
      end
      rde_pkg::ST_CHK_A: begin
        if (sym_bad) begin
          state_next = rde_pkg::ST_IDLE;
        end else if (last_a) begin
          state_next = rde_pkg::ST_DIV_GO;
        end else begin
          state_next = rde_pkg::ST_CHK_B;
        end
      end
      rde_pkg::ST_CHK_B: begin
        if (sym_dup) begin
          state_next = rde_pkg::ST_IDLE;
        end else if (last_b) begin
          state_next = rde_pkg::ST_CHK_A;
        end
      end
      rde_pkg::ST_DIV_GO: begin
        state_next = rde_pkg::ST_DIV_WAIT;
      end
      rde_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          if (!digits_done) begin
            state_next = rde_pkg::ST_DIV_GO;
          end else if (neg) begin
            state_next = rde_pkg::ST_SIGN;
          end else begin
            state_next = rde_pkg::ST_POP;
          end
        end
      end
      rde_pkg::ST_SIGN: begin
        if (out_free) begin
          state_next = rde_pkg::ST_POP;
        end
      end
      rde_pkg::ST_POP: begin
        state_next = rde_pkg::ST_LOOK;
      end
      rde_pkg::ST_LOOK: begin
        state_next = rde_pkg::ST_EMIT;
      end
      rde_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = (k_idx == '0) ? rde_pkg::ST_IDLE : rde_pkg::ST_POP;
        end
      end
      default: begin
        state_next = rde_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    alpha_rd_en   = 1'b0;
    alpha_raddr   = '0;
    div_start     = 1'b0;
    stack_we      = 1'b0;
    stack_rd      = 1'b0;
    out_load      = 1'b0;
    out_load_char = alpha_rdata;
    out_load_last = 1'b0;
    req.ready     = 1'b0;
    case (state)
      rde_pkg::ST_IDLE: begin
        req.ready   = 1'b1;
        alpha_rd_en = 1'b1;
      end
      rde_pkg::ST_CHK_A: begin
        alpha_rd_en = 1'b1;
        alpha_raddr = AW'(a_inc);
      end
      rde_pkg::ST_CHK_B: begin
        alpha_rd_en = 1'b1;
        alpha_raddr = last_b ? AW'(a_inc) : AW'(b_inc);
      end
      rde_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
      end
      rde_pkg::ST_DIV_WAIT: begin
        stack_we = div_done;
      end
      rde_pkg::ST_SIGN: begin
        out_load      = out_free;
        out_load_char = rde_pkg::CH_MINUS;
      end
      rde_pkg::ST_POP: begin
        stack_rd = 1'b1;
      end
      rde_pkg::ST_LOOK: begin
        alpha_rd_en = 1'b1;
        alpha_raddr = stack_q;
      end
      rde_pkg::ST_EMIT: begin
        out_load      = out_free;
        out_load_last = (k_idx == '0);
      end
      default: begin
        alpha_rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rde_pkg::ST_IDLE;
      digit_count <= rde_pkg::DIGIT_COUNT_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (digit_count_we) begin
        digit_count <= digit_count_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char <= out_load_char;
      out_last <= out_load_last;
    end
    if (stack_we) begin
      stack[nd[IW-1:0]] <= div_rem[AW-1:0];
    end
    if (stack_rd) begin
      stack_q <= stack[k_idx];
    end
    case (state)
      rde_pkg::ST_IDLE: begin
        neg   <= raw[31];
        mag   <= raw[31] ? (32'd0 - raw) : raw;
        radix <= CW'(digit_count);
        a_idx <= '0;
        nd    <= '0;
      end
      rde_pkg::ST_CHK_A: begin
        sym_a <= alpha_rdata;
        b_idx <= a_inc;
      end
      rde_pkg::ST_CHK_B: begin
        if (last_b) begin
          a_idx <= a_inc;
        end else begin
          b_idx <= b_inc;
        end
      end
      rde_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          mag   <= div_quo;
          nd    <= nd_inc;
          k_idx <= nd[IW-1:0];
        end
      end
      rde_pkg::ST_EMIT: begin
        if (out_free) begin
          k_idx <= IW'(k_idx - IW'(1));
        end
      end
      default: begin
        sym_a <= sym_a;
      end
    endcase
  end

  assign rsp.valid    = out_valid;
  assign rsp.out_char = out_char;
  assign rsp.last     = out_last;

endmodule

/* src/rde_checker.sv */
// ----------------------------------------------------------------------------
// rde_checker: port-level checks for the radix digit emitter
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module rde_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_out_char,
  input logic       rsp_last
);

  // A stalled response word holds its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last))
    else $error("response word changed while stalled");

  // The minus sign is always followed by at least one digit.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_out_char == rde_pkg::CH_MINUS) |-> !rsp_last)
    else $error("minus sign flagged as the final character");

  // No request is taken while a conversion is still being delivered.
  a_busy_while_emitting: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> !req_ready)
    else $error("request accepted in the middle of a conversion");

endmodule

bind radix_digit_emitter_unit rde_checker u_rde_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_out_char (rsp.out_char),
  .rsp_last     (rsp.last)
);
